### rtl/core/jsonu_pkg.sv
// shared types, constants and utf-8 encoding functions for the json unescape block
// no dependencies
package jsonu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_LO  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_HI  = 8'h46;
    localparam logic [7:0] CHAR_LOWER_LO  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_HI  = 8'h66;
    localparam logic [3:0] LETTER_OFFSET  = 4'd9;

    localparam logic [15:0] UNIT_TWO_BYTE   = 16'h0080;
    localparam logic [15:0] UNIT_THREE_BYTE = 16'h0800;
    localparam logic [7:0]  LEAD_TWO        = 8'hc0;
    localparam logic [7:0]  LEAD_THREE      = 8'he0;
    localparam logic [7:0]  CONT_MARK       = 8'h80;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_ESCAPE  = 2'd1,
        MODE_UNICODE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        JOB_BYTE = 2'd0,
        JOB_UNIT = 2'd1,
        JOB_BAD  = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] value;
    } job_t;

    typedef logic [1:0] byte_idx_t;

    // bit 4 flags a valid hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
                 (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI))
        begin
            r = {1'b1, c[3:0] + LETTER_OFFSET};
        end
        return r;
    endfunction

    function automatic byte_idx_t job_len(input job_t j);
        byte_idx_t n;
        n = 2'd1;
        if (j.kind == JOB_UNIT)
        begin
            if (j.value < UNIT_TWO_BYTE)
                n = 2'd1;
            else if (j.value < UNIT_THREE_BYTE)
                n = 2'd2;
            else
                n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] job_byte(input job_t j, input byte_idx_t idx);
        logic [7:0] b;
        b = 8'h00;
        case (j.kind)
            JOB_BYTE: b = j.value[7:0];
            JOB_UNIT:
            begin
                if (j.value < UNIT_TWO_BYTE)
                    b = j.value[7:0];
                else if (j.value < UNIT_THREE_BYTE)
                    b = (idx == 2'd0) ? (LEAD_TWO | {3'b000, j.value[10:6]})
                                      : (CONT_MARK | {2'b00, j.value[5:0]});
                else if (idx == 2'd0)
                    b = LEAD_THREE | {4'b0000, j.value[15:12]};
                else if (idx == 2'd1)
                    b = CONT_MARK | {2'b00, j.value[11:6]};
                else
                    b = CONT_MARK | {2'b00, j.value[5:0]};
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/jsonu_front.sv
// front end: escape parser that turns characters into output jobs
// depends on jsonu_pkg
module jsonu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [7:0]      char_in,
    input  logic            q_full,
    output logic            job_wr,
    output jsonu_pkg::job_t job
);
    import jsonu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [11:0] code_accum_reg, code_accum_next;
    logic        accept;
    logic [4:0]  hex;

    assign accept = push && !q_full;
    assign hex    = hex_digit(char_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_PLAIN;
            digit_count_reg <= 2'd0;
            code_accum_reg  <= 12'd0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            digit_count_reg <= digit_count_next;
            code_accum_reg  <= code_accum_next;
        end
    end

    always_comb
    begin
        mode_next        = MODE_PLAIN;
        digit_count_next = 2'd0;
        code_accum_next  = 12'd0;
        job_wr           = 1'b0;
        job.kind         = JOB_BYTE;
        job.value        = {8'h00, char_in};
        unique case (mode_reg)
            MODE_ESCAPE:
            begin
                if (char_in == CHAR_U)
                    mode_next = MODE_UNICODE;
                else if (char_in == CHAR_BACKSLASH || char_in == CHAR_QUOTE)
                    job_wr = accept;
            end
            MODE_UNICODE:
            begin
                if (!hex[4])
                begin
                    job_wr    = accept;
                    job.kind  = JOB_BAD;
                    job.value = 16'h0000;
                end
                else if (digit_count_reg != 2'd3)
                begin
                    mode_next        = MODE_UNICODE;
                    digit_count_next = digit_count_reg + 2'd1;
                    code_accum_next  = {code_accum_reg[7:0], hex[3:0]};
                end
                else
                begin
                    job_wr    = accept;
                    job.kind  = JOB_UNIT;
                    job.value = {code_accum_reg, hex[3:0]};
                end
            end
            default:
            begin
                if (char_in == CHAR_BACKSLASH)
                    mode_next = MODE_ESCAPE;
                else
                    job_wr = accept;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (digit_count_reg != 2'd0) |-> (mode_reg == MODE_UNICODE))
        else $error("digit count set outside unicode escape");

endmodule

### rtl/core/jsonu_queue.sv
// short job queue between the parser and the utf-8 emitter
// depends on jsonu_pkg
module jsonu_queue #(
    parameter int DEPTH = jsonu_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  jsonu_pkg::job_t wr_job,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output jsonu_pkg::job_t rd_job
);
    import jsonu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
        else $error("job written into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> rd_valid)
        else $error("job taken from an empty queue");

endmodule

### rtl/core/jsonu_back.sv
// back end: expands queued jobs into utf-8 bytes behind an output register
// depends on jsonu_pkg
module jsonu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  jsonu_pkg::job_t job,
    output logic            job_take,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      out_byte,
    output logic            last_in_run,
    output logic            bad_escape
);
    import jsonu_pkg::*;

    byte_idx_t  idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_bad_reg;
    logic       out_free;
    logic       load;
    logic       is_last;

    assign out_free = !out_valid_reg || pop;
    assign load     = job_valid && out_free;
    assign is_last  = (idx_reg == job_len(job) - 2'd1);
    assign job_take = load && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = job_valid;
        if (load)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= job_byte(job, idx_reg);
            out_last_reg <= is_last;
            out_bad_reg  <= (job.kind == JOB_BAD);
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_in_run = out_last_reg;
    assign bad_escape  = out_bad_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_last_reg && out_byte_reg == 8'h00))
        else $error("error transaction not a single zero byte");

    assert property (@(posedge clk) disable iff (!rst_n) idx_reg != 2'd3)
        else $error("byte index out of range");

endmodule

### rtl/core/json_unescape_utf8_top.sv
// json string unescape to utf-8: parser front end, job queue, utf-8 back end
// depends on jsonu_pkg, jsonu_front, jsonu_queue, jsonu_back
// an accepted character passes the job queue and then the back end output register
// throughput: one character per cycle in unless full, one result byte per cycle out while popped
// a unicode escape yields up to three bytes; the job queue absorbs the burst
// reset: asynchronous, parser returns to plain text, queue and output empty
module json_unescape_utf8_top #(
    parameter int DEPTH = jsonu_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_in_run,
    output logic       bad_escape
);
    import jsonu_pkg::*;

    logic q_full;
    logic job_wr;
    job_t wr_job;
    logic job_valid;
    job_t rd_job;
    logic job_take;

    assign full = q_full;

    jsonu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .char_in (char_in),
        .q_full  (q_full),
        .job_wr  (job_wr),
        .job     (wr_job)
    );

    jsonu_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_wr),
        .wr_job   (wr_job),
        .full     (q_full),
        .rd_en    (job_take),
        .rd_valid (job_valid),
        .rd_job   (rd_job)
    );

    jsonu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (rd_job),
        .job_take    (job_take),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_in_run (last_in_run),
        .bad_escape  (bad_escape)
    );

endmodule

### dv/json_unescape_utf8_checker.sv
// checker for json_unescape_utf8_top: predicts the decoded bytes of every accepted
// character and compares each popped transaction against them in order
// depends on jsonu_pkg
`timescale 1ns / 100ps

module json_unescape_utf8_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] char_in,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_byte,
    input  logic       last_in_run,
    input  logic       bad_escape,
    output int         mismatch_count,
    output int         pending_count
);
    import jsonu_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       bad;
    } decoded_byte_t;

    decoded_byte_t expected_bytes[$];

    mode_t       mode_q;
    logic [1:0]  digits_q;
    logic [11:0] accum_q;

    // bit 4 set for a hex digit, bits 3:0 its value
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI)
        begin
            d = c - CHAR_DIGIT_LO;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI)
        begin
            d = c - CHAR_UPPER_LO + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI)
        begin
            d = c - CHAR_LOWER_LO + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    task automatic queue_byte(input logic [7:0] v, input logic l, input logic b);
        expected_bytes.push_back('{v, l, b});
    endtask

    task automatic back_to_plain();
        mode_q   = MODE_PLAIN;
        digits_q = 2'd0;
        accum_q  = 12'd0;
    endtask

    task automatic decode_char(input logic [7:0] c);
        logic [4:0]  nib;
        logic [15:0] code_unit;
        nib       = nibble_of(c);
        code_unit = {accum_q, nib[3:0]};
        case (mode_q)
            MODE_ESCAPE:
            begin
                if (c == CHAR_U)
                begin
                    mode_q   = MODE_UNICODE;
                    digits_q = 2'd0;
                    accum_q  = 12'd0;
                end
                else
                begin
                    back_to_plain();
                    if (c == CHAR_BACKSLASH || c == CHAR_QUOTE)
                        queue_byte(c, 1'b1, 1'b0);
                end
            end
            MODE_UNICODE:
            begin
                if (!nib[4])
                begin
                    back_to_plain();
                    queue_byte(8'h00, 1'b1, 1'b1);
                end
                else if (digits_q != 2'd3)
                begin
                    accum_q  = code_unit[11:0];
                    digits_q = digits_q + 2'd1;
                end
                else
                begin
                    back_to_plain();
                    if (code_unit < UNIT_TWO_BYTE)
                    begin
                        queue_byte(code_unit[7:0], 1'b1, 1'b0);
                    end
                    else if (code_unit < UNIT_THREE_BYTE)
                    begin
                        queue_byte(LEAD_TWO | {3'b000, code_unit[10:6]}, 1'b0, 1'b0);
                        queue_byte(CONT_MARK | {2'b00, code_unit[5:0]}, 1'b1, 1'b0);
                    end
                    else
                    begin
                        queue_byte(LEAD_THREE | {4'b0000, code_unit[15:12]}, 1'b0, 1'b0);
                        queue_byte(CONT_MARK | {2'b00, code_unit[11:6]}, 1'b0, 1'b0);
                        queue_byte(CONT_MARK | {2'b00, code_unit[5:0]}, 1'b1, 1'b0);
                    end
                end
            end
            default:
            begin
                if (c == CHAR_BACKSLASH)
                begin
                    mode_q   = MODE_ESCAPE;
                    digits_q = 2'd0;
                    accum_q  = 12'd0;
                end
                else
                begin
                    back_to_plain();
                    queue_byte(c, 1'b1, 1'b0);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_byte_t want;
        if (!rst_n)
        begin
            back_to_plain();
            expected_bytes.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t unexpected output transaction: byte %02h last %b bad %b",
                                 $realtime, out_byte, last_in_run, bad_escape);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.value || last_in_run !== want.last ||
                        bad_escape !== want.bad)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t mismatch: expected byte %02h last %b bad %b,",
                                      " got byte %02h last %b bad %b"},
                                     $realtime, want.value, want.last, want.bad,
                                     out_byte, last_in_run, bad_escape);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (push && !full)
                decode_char(char_in);
        end
        pending_count = expected_bytes.size();
    end

endmodule

### dv/testbench.sv
// top of the json_unescape_utf8_top testbench: clock, reset, character stimulus,
// output back-pressure, watchdog and verdict
// depends on jsonu_pkg, json_unescape_utf8_top and json_unescape_utf8_checker
`timescale 1ns / 100ps

module testbench;
    import jsonu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int DIRECTED_LEN   = 23;

    // extremes, simple escapes, unknown escape, a mixed-case two byte unit, a mixed-case
    // three byte surrogate unit and a non-hex digit
    localparam logic [7:0] DIRECTED_CHARS [DIRECTED_LEN] = '{
        8'h00, 8'hff,
        8'h5c, 8'h5c,
        8'h5c, 8'h22,
        8'h5c, 8'h71,
        8'h5c, 8'h75, 8'h30, 8'h37, 8'h46, 8'h66,
        8'h5c, 8'h75, 8'h44, 8'h62, 8'h63, 8'h64,
        8'h5c, 8'h75, 8'h47
    };

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       push    = 1'b0;
    logic [7:0] char_in = 8'h00;
    logic       pop     = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       bad_escape;

    int mismatch_count;
    int pending_count;
    int send_idle_pct    = 8;
    int recv_idle_pct    = 55;
    int chars_sent       = 0;
    int quiet_cycles     = 0;
    int stall_count      = 0;
    bit long_stall_start = 1'b0;

    json_unescape_utf8_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_in     (char_in),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_in_run (last_in_run),
        .bad_escape  (bad_escape)
    );

    json_unescape_utf8_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .char_in        (char_in),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .last_in_run    (last_in_run),
        .bad_escape     (bad_escape),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: random pop gaps, plus one long hold-off once requested
    always @(negedge clk)
    begin
        if (long_stall_start && stall_count < LONG_STALL)
        begin
            stall_count = stall_count + 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        char_in <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        chars_sent = chars_sent + 1;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CHAR_DIGIT_LO + n;
        return ($urandom_range(1) ? CHAR_UPPER_LO : CHAR_LOWER_LO) + n - 8'd10;
    endfunction

    task automatic send_random_run();
        int          pick;
        int          k;
        int          n;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] code_unit;
        logic [7:0]  c;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            send_char(8'($urandom_range(255)));
        end
        else if (pick < 50)
        begin
            send_char(CHAR_BACKSLASH);
            k = $urandom_range(2);
            if (k == 0)
                send_char(CHAR_BACKSLASH);
            else if (k == 1)
                send_char(CHAR_QUOTE);
            else
                send_char(8'($urandom_range(255)));
        end
        else if (pick < 88)
        begin
            k = $urandom_range(2);
            lo = (k == 0) ? 16'h0000 : (k == 1) ? UNIT_TWO_BYTE : UNIT_THREE_BYTE;
            hi = (k == 0) ? 16'h007f : (k == 1) ? 16'h07ff : 16'hffff;
            if ($urandom_range(7) == 0)
                code_unit = $urandom_range(1) ? lo : hi;
            else
                code_unit = 16'($urandom_range(hi, lo));
            send_char(CHAR_BACKSLASH);
            send_char(CHAR_U);
            for (n = 3; n >= 0; n--)
                send_char(hex_char(code_unit[n*4 +: 4]));
        end
        else
        begin
            // broken unicode escape: up to three good digits, then a non-hex one
            send_char(CHAR_BACKSLASH);
            send_char(CHAR_U);
            repeat ($urandom_range(3))
                send_char(hex_char(4'($urandom_range(15))));
            c = 8'($urandom_range(255));
            while ((c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
                   (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
                   (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI))
                c = 8'($urandom_range(255));
            send_char(c);
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_CHARS[i])
            send_char(DIRECTED_CHARS[i]);

        // sender busy, receiver slow, with one long hold-off to fill the block
        long_stall_start = 1'b1;
        while (chars_sent < 125)
            send_random_run();

        send_idle_pct = 55;
        recv_idle_pct = 8;
        while (chars_sent < 250)
            send_random_run();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (chars_sent < 370)
            send_random_run();

        push <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
